// ===== design/wsfp_pkg.sv =====
// Package for the WebSocket frame parser: phase type, opcodes and result kinds.
`timescale 1ns / 1ps

package wsfp_pkg;

    typedef enum logic [2:0] {
        PH_HDR1   = 3'd0,
        PH_HDR2   = 3'd1,
        PH_EXT16  = 3'd2,
        PH_EXT64  = 3'd3,
        PH_MASK   = 3'd4,
        PH_DATA   = 3'd5,
        PH_CLOSED = 3'd6
    } phase_t;

    localparam logic [3:0] OP_TEXT  = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING  = 4'h9;

    localparam logic [1:0] KIND_TEXT  = 2'd0;
    localparam logic [1:0] KIND_PING  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    localparam logic [2:0] EXT16_BYTES = 3'd2;
    localparam logic [2:0] MASK_BYTES  = 3'd4;

endpackage

// ===== design/websocket_frame_parser_top.sv =====
// WebSocket receive frame parser: header decode, unmasking and payload delivery.
//
// Input channel (s_valid/s_ready/s_rx_byte) takes the received stream, one byte
// per beat. Result channel (m_valid/m_ready/m_*) gives at most one result beat
// per input beat: a text or ping payload byte (unmasked), an empty-frame marker,
// or the close marker. Header bytes and payload of other opcodes give no beat.
// A beat accepted into the input register is parsed from there into the output
// register once the output register is empty or being taken.
// Throughput is one byte per cycle; the input register and the output register
// each advance whenever the output register is empty or being taken.
// When m_ready is low while a result waits, the output register holds and the
// parse stage waits; an empty input register takes one more beat, then s_ready drops.
// After a close frame ends, all further bytes are taken and ignored.
// Reset (aresetn low, synchronous) returns the parser to expect the first
// header byte of a new frame and empties both registers.
// LENGTH_WIDTH sets the payload length counter; longer 64-bit lengths
// saturate to all ones.
`timescale 1ns / 1ps

module websocket_frame_parser_top #(
    parameter int LENGTH_WIDTH = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_data_byte,
    output logic [1:0] m_kind,
    output logic       m_fin_flag,
    output logic       m_end_of_frame,
    output logic       m_no_byte
);

    localparam logic [LENGTH_WIDTH-1:0] LEN_ONES = {LENGTH_WIDTH{1'b1}};
    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE  = LENGTH_WIDTH'(1);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    proc;

    wsfp_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]              opcode_reg, opcode_next;
    logic                    fin_reg, fin_next;
    logic                    masked_reg, masked_next;
    logic [LENGTH_WIDTH-1:0] rem_reg, rem_next;
    logic [2:0]              hcount_reg, hcount_next;
    logic [31:0]             key_reg, key_next;
    logic [1:0]              midx_reg, midx_next;

    logic                    res_valid;
    logic [7:0]              res_data;
    logic [1:0]              res_kind;
    logic                    res_eof;
    logic                    res_nob;
    logic                    hdr_done;
    logic                    done_empty;
    logic                    len_done;
    logic [LENGTH_WIDTH-1:0] rem_shift;
    logic [7:0]              key_byte;

    logic                    out_valid_reg;
    logic [7:0]              out_data_reg;
    logic [1:0]              out_kind_reg;
    logic                    out_fin_reg;
    logic                    out_eof_reg;
    logic                    out_nob_reg;

    assign proc    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || proc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_byte_reg <= s_rx_byte;
        end
    end

    assign key_byte = key_reg[31 - 8 * midx_reg -: 8];

    always_comb begin
        if (rem_reg[LENGTH_WIDTH-1 -: 8] != 8'd0 || rem_reg == LEN_ONES) begin
            rem_shift = LEN_ONES;
        end else begin
            rem_shift = {rem_reg[LENGTH_WIDTH-9:0], in_byte_reg};
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        rem_next    = rem_reg;
        hcount_next = hcount_reg;
        key_next    = key_reg;
        midx_next   = midx_reg;
        res_valid   = 1'b0;
        res_data    = 8'd0;
        res_kind    = wsfp_pkg::KIND_TEXT;
        res_eof     = 1'b0;
        res_nob     = 1'b0;
        hdr_done    = 1'b0;
        done_empty  = 1'b0;
        len_done    = 1'b0;

        unique case (phase_reg) inside
            wsfp_pkg::PH_HDR2: begin
                masked_next = in_byte_reg[7];
                rem_next    = '0;
                hcount_next = 3'd0;
                if (in_byte_reg[6:0] == wsfp_pkg::LEN7_EXT16) begin
                    phase_next = wsfp_pkg::PH_EXT16;
                end else if (in_byte_reg[6:0] == wsfp_pkg::LEN7_EXT64) begin
                    phase_next = wsfp_pkg::PH_EXT64;
                end else begin
                    rem_next = LENGTH_WIDTH'(in_byte_reg[6:0]);
                    len_done = 1'b1;
                end
            end
            wsfp_pkg::PH_EXT16, wsfp_pkg::PH_EXT64: begin
                rem_next    = rem_shift;
                hcount_next = hcount_reg + 3'd1;
                if (phase_reg == wsfp_pkg::PH_EXT16) begin
                    len_done = (hcount_next == wsfp_pkg::EXT16_BYTES);
                end else begin
                    len_done = (hcount_next == 3'd0);
                end
            end
            wsfp_pkg::PH_MASK: begin
                key_next    = {key_reg[23:0], in_byte_reg};
                hcount_next = hcount_reg + 3'd1;
                hdr_done    = (hcount_next >= wsfp_pkg::MASK_BYTES);
            end
            wsfp_pkg::PH_DATA: begin
                midx_next = midx_reg + 2'd1;
                rem_next  = rem_reg - LEN_ONE;
                if (opcode_reg == wsfp_pkg::OP_TEXT || opcode_reg == wsfp_pkg::OP_PING) begin
                    res_valid = 1'b1;
                    res_data  = masked_reg ? (in_byte_reg ^ key_byte) : in_byte_reg;
                    res_kind  = (opcode_reg == wsfp_pkg::OP_TEXT) ? wsfp_pkg::KIND_TEXT
                                                                  : wsfp_pkg::KIND_PING;
                    res_eof   = (rem_reg == LEN_ONE);
                    if (rem_reg == LEN_ONE) begin
                        phase_next = wsfp_pkg::PH_HDR1;
                    end
                end else begin
                    done_empty = (rem_reg == LEN_ONE);
                end
            end
            wsfp_pkg::PH_CLOSED: begin
            end
            default: begin
                fin_next    = in_byte_reg[7];
                opcode_next = in_byte_reg[3:0];
                phase_next  = wsfp_pkg::PH_HDR2;
            end
        endcase

        if (len_done) begin
            hcount_next = 3'd0;
            if (masked_next) begin
                phase_next = wsfp_pkg::PH_MASK;
                key_next   = '0;
            end else begin
                hdr_done = 1'b1;
            end
        end

        if (hdr_done) begin
            midx_next   = 2'd0;
            hcount_next = 3'd0;
            if (rem_next == '0) begin
                done_empty = 1'b1;
            end else begin
                phase_next = wsfp_pkg::PH_DATA;
            end
        end

        if (done_empty) begin
            phase_next = wsfp_pkg::PH_HDR1;
            res_eof    = 1'b1;
            res_nob    = 1'b1;
            res_data   = 8'd0;
            case (opcode_reg)
                wsfp_pkg::OP_TEXT: begin
                    res_valid = 1'b1;
                    res_kind  = wsfp_pkg::KIND_TEXT;
                end
                wsfp_pkg::OP_PING: begin
                    res_valid = 1'b1;
                    res_kind  = wsfp_pkg::KIND_PING;
                end
                wsfp_pkg::OP_CLOSE: begin
                    res_valid  = 1'b1;
                    res_kind   = wsfp_pkg::KIND_CLOSE;
                    phase_next = wsfp_pkg::PH_CLOSED;
                end
                default: begin
                    res_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= wsfp_pkg::PH_HDR1;
            opcode_reg <= 4'd0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            rem_reg    <= '0;
            hcount_reg <= 3'd0;
            key_reg    <= 32'd0;
            midx_reg   <= 2'd0;
        end else if (proc) begin
            phase_reg  <= phase_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            rem_reg    <= rem_next;
            hcount_reg <= hcount_next;
            key_reg    <= key_next;
            midx_reg   <= midx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= proc && res_valid;
        end
        if (proc && res_valid) begin
            out_data_reg <= res_data;
            out_kind_reg <= res_kind;
            out_fin_reg  <= fin_reg;
            out_eof_reg  <= res_eof;
            out_nob_reg  <= res_nob;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_data_byte    = out_data_reg;
    assign m_kind         = out_kind_reg;
    assign m_fin_flag     = out_fin_reg;
    assign m_end_of_frame = out_eof_reg;
    assign m_no_byte      = out_nob_reg;

endmodule
